// ===== hw/rtl/gcib_pkg.sv =====
// Shared constants, a type and a function for the great-circle bearing pipeline.
`default_nettype none
package gcib_pkg;
    localparam int FracBits = 22;
    localparam int Stages   = 24;
    localparam int CW       = 36;

    typedef logic signed [CW-1:0] t_cval;

    localparam logic signed [CW-1:0] QOne    = 36'sd1073741824;
    localparam logic signed [CW-1:0] GainInv = 36'sd652032874;

    function automatic logic [31:0] turn_at(input int i);
        logic [31:0] t [0:31];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001, 32'h00000000};
        return t[i];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gcib_sincos.sv =====
// Pipelined rotation CORDIC giving sine and cosine of a binary angle.
`default_nettype none
module gcib_sincos (
    input  wire logic                 i_clk,
    input  wire logic [31:0]          i_angle,
    output gcib_pkg::t_cval           o_cos,
    output gcib_pkg::t_cval           o_sin
);
    localparam int N = gcib_pkg::Stages;

    gcib_pkg::t_cval    r_x [0:N];
    gcib_pkg::t_cval    r_y [0:N];
    logic signed [32:0] r_z [0:N];
    logic [0:N]         r_flip;
    logic [0:N]         r_exact;
    gcib_pkg::t_cval    r_ec [0:N];
    gcib_pkg::t_cval    r_es [0:N];

    logic [1:0]  quarter;
    logic [31:0] a_adj;
    gcib_pkg::t_cval ec, es;

    always_comb begin
        quarter = i_angle[31:30];
        a_adj   = (quarter == 2'd1 || quarter == 2'd2) ? i_angle - 32'h80000000 : i_angle;
        ec = (quarter == 2'd0) ? gcib_pkg::QOne :
             (quarter == 2'd2) ? -gcib_pkg::QOne : '0;
        es = (quarter == 2'd1) ? gcib_pkg::QOne :
             (quarter == 2'd3) ? -gcib_pkg::QOne : '0;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]     <= gcib_pkg::GainInv;
        r_y[0]     <= '0;
        r_z[0]     <= {a_adj[31], a_adj};
        r_flip[0]  <= (quarter == 2'd1 || quarter == 2'd2);
        r_exact[0] <= (i_angle[29:0] == 30'd0);
        r_ec[0]    <= ec;
        r_es[0]    <= es;
    end

    for (genvar i = 0; i < N; i++) begin : g_st
        localparam logic signed [32:0] T = {1'b0, gcib_pkg::turn_at(i)};
        always_ff @(posedge i_clk) begin
            if (!r_z[i][32]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - T;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + T;
            end
            r_flip[i+1]  <= r_flip[i];
            r_exact[i+1] <= r_exact[i];
            r_ec[i+1]    <= r_ec[i];
            r_es[i+1]    <= r_es[i];
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos <= r_exact[N] ? r_ec[N] : (r_flip[N] ? -r_x[N] : r_x[N]);
        o_sin <= r_exact[N] ? r_es[N] : (r_flip[N] ? -r_y[N] : r_y[N]);
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gcib_atan.sv =====
// Pipelined vectoring CORDIC giving a binary angle from east and north parts.
`default_nettype none
module gcib_atan (
    input  wire logic            i_clk,
    input  wire gcib_pkg::t_cval i_east,
    input  wire gcib_pkg::t_cval i_north,
    output logic [31:0]          o_angle
);
    localparam int N = gcib_pkg::Stages;
    localparam int W = gcib_pkg::CW + 2;

    logic signed [W-1:0] r_re [0:N];
    logic signed [W-1:0] r_im [0:N];
    logic [31:0]         r_z  [0:N];
    logic [0:N]          r_zero;

    logic signed [W-1:0] e, n;
    always_comb begin
        e = W'(i_east);
        n = W'(i_north);
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_east == '0) && (i_north == '0);
        if (n < 0) begin
            r_re[0] <= -n;
            r_im[0] <= -e;
            r_z[0]  <= 32'h80000000;
        end else begin
            r_re[0] <= n;
            r_im[0] <= e;
            r_z[0]  <= '0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_st
        localparam logic [31:0] T = gcib_pkg::turn_at(i);
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_im[i] > 0) begin
                r_re[i+1] <= r_re[i] + (r_im[i] >>> i);
                r_im[i+1] <= r_im[i] - (r_re[i] >>> i);
                r_z[i+1]  <= r_z[i] + T;
            end else if (r_im[i] < 0) begin
                r_re[i+1] <= r_re[i] - (r_im[i] >>> i);
                r_im[i+1] <= r_im[i] + (r_re[i] >>> i);
                r_z[i+1]  <= r_z[i] - T;
            end else begin
                r_re[i+1] <= r_re[i];
                r_im[i+1] <= r_im[i];
                r_z[i+1]  <= r_z[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_angle <= r_zero[N] ? 32'd0 : r_z[N];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/great_circle_initial_bearing_unit.sv =====
// Top level of the great-circle initial bearing pipeline.
// Channel | Direction | Handshake        | Fields
// in      | input     | i_start, o_busy  | first/second latitude, longitude
// out     | output    | o_done strobe    | o_bearing
// Accepts one beat every cycle; o_busy stays low.
// The path runs through the degree conversion, the sine/cosine CORDIC chains,
// the products, the arctangent CORDIC chain and the output scaling.
// Reset clears only the valid line; payload registers run freely.
// The receiver cannot stall, so no backpressure exists.
`default_nettype none
module great_circle_initial_bearing_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [29:0] i_first_latitude,
    input  wire logic signed [30:0] i_first_longitude,
    input  wire logic signed [29:0] i_second_latitude,
    input  wire logic signed [30:0] i_second_longitude,
    output logic                    o_done,
    output logic [30:0]             o_bearing
);
    localparam int F   = gcib_pkg::FracBits;
    localparam int LAT = gcib_pkg::Stages + 2 + 1 + 4;
    localparam int TOT = LAT + gcib_pkg::Stages + 2 + 2;

    localparam logic signed [31:0] LatLim = 32'sd90 <<< F;
    localparam logic signed [31:0] LonLim = 32'sd180 <<< F;

    localparam logic [30:0] Recip45      = 31'd1527099484;
    localparam logic [19:0] Recip45Small = 20'd11651;

    logic [TOT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[TOT-2:0], i_start};
    end
    assign o_busy = 1'b0;

    function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                  input logic signed [31:0] l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // degrees -> turn: +-floor(|d| * 128 / 45), split as 128*(|d|/45) + 128*rem/45
    logic signed [31:0] crd [0:3];
    always_comb begin
        crd[0] = clampv(32'(i_first_latitude), LatLim);
        crd[1] = clampv(32'(i_second_latitude), LatLim);
        crd[2] = clampv(32'(i_first_longitude), LonLim);
        crd[3] = clampv(32'(i_second_longitude), LonLim);
    end

    logic [29:0] r_mag_a [0:3];
    logic [3:0]  r_neg_a;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_neg_a[k] <= crd[k][31];
            r_mag_a[k] <= crd[k][31] ? 30'(-crd[k]) : 30'(crd[k]);
        end
    end

    logic [60:0] quo_p [0:3];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            quo_p[k] = 61'(r_mag_a[k]) * 61'(Recip45);
        end
    end

    logic [29:0] r_mag_b [0:3];
    logic [24:0] r_quo_b [0:3];
    logic [3:0]  r_neg_b;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_quo_b[k] <= 25'(quo_p[k] >> 36);
            r_mag_b[k] <= r_mag_a[k];
        end
        r_neg_b <= r_neg_a;
    end

    logic [24:0] r_quo_c [0:3];
    logic [5:0]  r_rem_c [0:3];
    logic [3:0]  r_neg_c;
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_rem_c[k] <= 6'(r_mag_b[k] - 30'(r_quo_b[k]) * 30'd45);
            r_quo_c[k] <= r_quo_b[k];
        end
        r_neg_c <= r_neg_b;
    end

    logic [6:0]  frac [0:3];
    logic [31:0] trn  [0:3];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            frac[k] = 7'((20'(r_rem_c[k]) * Recip45Small) >> 12);
            trn[k]  = r_neg_c[k] ? -{r_quo_c[k], frac[k]} : {r_quo_c[k], frac[k]};
        end
    end

    logic [31:0] r_t1, r_t2, r_td;
    always_ff @(posedge i_clk) begin
        r_t1 <= trn[0];
        r_t2 <= trn[1];
        r_td <= trn[3] - trn[2];
    end

    gcib_pkg::t_cval c1, s1, c2, s2, cd, sd;
    gcib_sincos u_sc1 (.i_clk(i_clk), .i_angle(r_t1), .o_cos(c1), .o_sin(s1));
    gcib_sincos u_sc2 (.i_clk(i_clk), .i_angle(r_t2), .o_cos(c2), .o_sin(s2));
    gcib_sincos u_scd (.i_clk(i_clk), .i_angle(r_td), .o_cos(cd), .o_sin(sd));

    logic signed [31:0] m_sd, m_c2, m_c1, m_s2, m_s1, m_b, m_cd;
    logic signed [63:0] p_e, p_n1, p_n2, p_n3;
    gcib_pkg::t_cval r_e, r_a, r_b, r_cd, r_e2, r_n;
    always_comb begin
        m_sd = 32'(sd);
        m_c2 = 32'(c2);
        m_c1 = 32'(c1);
        m_s2 = 32'(s2);
        m_s1 = 32'(s1);
        m_b  = 32'(r_b);
        m_cd = 32'(r_cd);
        p_e  = 64'(m_sd) * 64'(m_c2);
        p_n1 = 64'(m_c1) * 64'(m_s2);
        p_n2 = 64'(m_s1) * 64'(m_c2);
        p_n3 = 64'(m_b) * 64'(m_cd);
    end
    always_ff @(posedge i_clk) begin
        r_e  <= gcib_pkg::CW'(p_e >>> 30);
        r_a  <= gcib_pkg::CW'(p_n1 >>> 30);
        r_b  <= gcib_pkg::CW'(p_n2 >>> 30);
        r_cd <= cd;
        r_e2 <= r_e;
        r_n  <= r_a - gcib_pkg::CW'(p_n3 >>> 30);
    end

    logic [31:0] ang;
    gcib_atan u_at (.i_clk(i_clk), .i_east(r_e2), .i_north(r_n), .o_angle(ang));

    logic [41:0] deg;
    assign deg = 42'(ang) * 42'd360;
    always_ff @(posedge i_clk) begin
        o_bearing <= 31'(deg >> (32 - F));
    end
    assign o_done = r_vld[TOT-1];
endmodule
`default_nettype wire
